### design/jlvp_pkg.sv
package jlvp_pkg;

   // Field widths
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned LIMIT_W  = 31;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned UPC_W    = 4;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_TICK_PERIOD      = 3'd0,
      CSR_SPEED_MAX        = 3'd1,
      CSR_ACCEL_LIMIT      = 3'd2,
      CSR_ACCEL_JERK_LIMIT = 3'd3,
      CSR_DECEL_LIMIT      = 3'd4,
      CSR_DECEL_JERK_LIMIT = 3'd5
   } csr_index_type;

   // Configuration reset values
   localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST      = 16'd1311;
   localparam logic [LIMIT_W-1:0]  SPEED_MAX_RST        = 31'd13107;
   localparam logic [LIMIT_W-1:0]  ACCEL_LIMIT_RST      = 31'd26214;
   localparam logic [LIMIT_W-1:0]  ACCEL_JERK_LIMIT_RST = 31'd26214;
   localparam logic [LIMIT_W-1:0]  DECEL_LIMIT_RST      = 31'd52429;
   localparam logic [LIMIT_W-1:0]  DECEL_JERK_LIMIT_RST = 31'd52429;

   // Direction codes
   localparam logic signed [1:0] DIR_FWD  = 2'sb01;
   localparam logic signed [1:0] DIR_STOP = 2'sb00;
   localparam logic signed [1:0] DIR_REV  = 2'sb11;

   // Braking margin in LSBs
   localparam logic [DATA_W:0] BRAKE_MARGIN = 33'd7;

   // Datapath actions of one control word
   typedef enum logic [3:0] {
      ACT_NONE    = 4'd0,
      ACT_SETUP   = 4'd1,
      ACT_SAVE_SQ = 4'd2,
      ACT_BRAKE   = 4'd3,
      ACT_ACCEL   = 4'd4,
      ACT_VEL     = 4'd5,
      ACT_ZERO    = 4'd6,
      ACT_DIR     = 4'd7,
      ACT_CLEAR   = 4'd8,
      ACT_RESULT  = 4'd9
   } act_type;

   // Multiplier operand loads
   typedef enum logic [2:0] {
      MUL_HOLD     = 3'd0,
      MUL_ACC_SQ   = 3'd1,
      MUL_ERR_JERK = 3'd2,
      MUL_JERK_DT  = 3'd3,
      MUL_SUM_DT   = 3'd4
   } mul_type;

   // Sequencing of the step counter
   typedef enum logic [2:0] {
      SEQ_NEXT      = 3'd0,
      SEQ_JUMP      = 3'd1,
      SEQ_DISPATCH  = 3'd2,
      SEQ_JUMP_GOAL = 3'd3,
      SEQ_FINISH    = 3'd4
   } seq_type;

   typedef struct packed {
      act_type           act;
      mul_type           mul;
      seq_type           seq;
      logic [UPC_W-1:0]  target;
   } ctrl_word_type;

   // Program addresses
   localparam logic [UPC_W-1:0] UPC_DISPATCH  = 4'd0;
   localparam logic [UPC_W-1:0] UPC_GO_TICK   = 4'd1;
   localparam logic [UPC_W-1:0] UPC_DIR       = 4'd2;
   localparam logic [UPC_W-1:0] UPC_CLEAR     = 4'd3;
   localparam logic [UPC_W-1:0] UPC_NOP       = 4'd4;
   localparam logic [UPC_W-1:0] UPC_SETUP     = 4'd5;
   localparam logic [UPC_W-1:0] UPC_LOAD_KD   = 4'd6;
   localparam logic [UPC_W-1:0] UPC_SAVE_SQ   = 4'd7;
   localparam logic [UPC_W-1:0] UPC_BRAKE     = 4'd8;
   localparam logic [UPC_W-1:0] UPC_WAIT_JERK = 4'd9;
   localparam logic [UPC_W-1:0] UPC_ACCEL     = 4'd10;
   localparam logic [UPC_W-1:0] UPC_LOAD_SUM  = 4'd11;
   localparam logic [UPC_W-1:0] UPC_WAIT_SUM  = 4'd12;
   localparam logic [UPC_W-1:0] UPC_VEL       = 4'd13;
   localparam logic [UPC_W-1:0] UPC_ZERO      = 4'd14;
   localparam logic [UPC_W-1:0] UPC_DONE      = 4'd15;

   // Control store: one word per step
   function automatic ctrl_word_type ucode(input logic [UPC_W-1:0] upc);
      ctrl_word_type cw;
      cw.act    = ACT_NONE;
      cw.mul    = MUL_HOLD;
      cw.seq    = SEQ_NEXT;
      cw.target = UPC_DISPATCH;
      case (upc)
         // branch on the operation code into the jump row
         UPC_DISPATCH: begin
            cw.seq    = SEQ_DISPATCH;
            cw.target = UPC_GO_TICK;
         end
         UPC_GO_TICK: begin
            cw.seq    = SEQ_JUMP;
            cw.target = UPC_SETUP;
         end
         UPC_DIR: begin
            cw.act    = ACT_DIR;
            cw.seq    = SEQ_JUMP;
            cw.target = UPC_DONE;
         end
         UPC_CLEAR: begin
            cw.act    = ACT_CLEAR;
            cw.seq    = SEQ_JUMP;
            cw.target = UPC_DONE;
         end
         UPC_NOP: begin
            cw.seq    = SEQ_JUMP;
            cw.target = UPC_DONE;
         end
         // tick: goal, limits, error; start a*a
         UPC_SETUP: begin
            cw.act    = ACT_SETUP;
            cw.mul    = MUL_ACC_SQ;
            cw.seq    = SEQ_JUMP_GOAL;
            cw.target = UPC_ZERO;
         end
         UPC_LOAD_KD: begin
            cw.mul = MUL_ERR_JERK;
         end
         UPC_SAVE_SQ: begin
            cw.act = ACT_SAVE_SQ;
         end
         UPC_BRAKE: begin
            cw.act = ACT_BRAKE;
            cw.mul = MUL_JERK_DT;
         end
         UPC_WAIT_JERK: begin
            cw.act = ACT_NONE;
         end
         UPC_ACCEL: begin
            cw.act = ACT_ACCEL;
         end
         UPC_LOAD_SUM: begin
            cw.mul = MUL_SUM_DT;
         end
         UPC_WAIT_SUM: begin
            cw.act = ACT_NONE;
         end
         UPC_VEL: begin
            cw.act    = ACT_VEL;
            cw.seq    = SEQ_JUMP;
            cw.target = UPC_DONE;
         end
         UPC_ZERO: begin
            cw.act    = ACT_ZERO;
            cw.seq    = SEQ_JUMP;
            cw.target = UPC_DONE;
         end
         UPC_DONE: begin
            cw.act = ACT_RESULT;
            cw.seq = SEQ_FINISH;
         end
         default: begin
            cw.seq    = SEQ_JUMP;
            cw.target = UPC_DONE;
         end
      endcase
      return cw;
   endfunction

   // Magnitude of a 32-bit two's complement value
   function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] x);
      logic [DATA_W-1:0] r;
      r = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
      return r;
   endfunction

endpackage

### design/jerk_limited_velocity_profiler_unit.sv
// Jerk-limited (S-curve) velocity planner for one axis in Q16.16. Each item is a
// tick, a direction command, a state clear or a no-op, and returns one result
// with the velocity, acceleration and jerk after the item. A small control store
// steps a datapath built around one shared 33x33 multiplier with registered
// operands and product; the braking test |goal - v| <= a*a/(2*jerk_limit) + 7 is
// done as a multiply-compare, so no divider is present. A tick sends a*a, the
// braking product, the jerk step and the velocity step in turn through the
// multiplier's two register stages, and zeroes acceleration and jerk instead
// when the velocity already sits on its goal. The next item can be accepted no
// earlier than the cycle after the last step of the previous one. A new item is
// taken while the previous result still waits on rsp_ready; it then holds in its
// last step until the result register frees. Configuration writes must only happen while idle.
module jerk_limited_velocity_profiler_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_operation,
   input  logic signed [1:0]                      req_direction,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [jlvp_pkg::DATA_W-1:0]     rsp_velocity,
   output logic signed [jlvp_pkg::DATA_W-1:0]     rsp_acceleration,
   output logic signed [jlvp_pkg::DATA_W-1:0]     rsp_jerk,
   input  logic                                   csr_write_enable,
   input  logic [2:0]                             csr_index,
   input  logic [jlvp_pkg::LIMIT_W-1:0]           csr_write_data
);

   // Configuration registers
   logic [jlvp_pkg::PERIOD_W-1:0] tick_period_ff, tick_period_in;
   logic [jlvp_pkg::LIMIT_W-1:0]  speed_max_ff, speed_max_in;
   logic [jlvp_pkg::LIMIT_W-1:0]  accel_limit_ff, accel_limit_in;
   logic [jlvp_pkg::LIMIT_W-1:0]  accel_jerk_ff, accel_jerk_in;
   logic [jlvp_pkg::LIMIT_W-1:0]  decel_limit_ff, decel_limit_in;
   logic [jlvp_pkg::LIMIT_W-1:0]  decel_jerk_ff, decel_jerk_in;

   // Planner state
   logic signed [31:0] vel_ff, vel_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] jrk_ff, jrk_in;
   logic signed [1:0]  dir_ff, dir_in;

   // Sequencer
   logic                          busy_ff, busy_in;
   logic [jlvp_pkg::UPC_W-1:0]    upc_ff, upc_in;
   logic [1:0]                    op_ff, op_in;
   logic signed [1:0]             dir_req_ff, dir_req_in;
   jlvp_pkg::ctrl_word_type       cw;

   // Tick scratch registers
   logic signed [31:0]            vg_ff, vg_in;
   logic signed [32:0]            err_ff, err_in;
   logic [jlvp_pkg::LIMIT_W-1:0]  am_ff, am_in;
   logic [jlvp_pkg::LIMIT_W-1:0]  jm_ff, jm_in;
   logic                          dr_neg_ff, dr_neg_in;
   logic [63:0]                   sq_ff, sq_in;
   logic signed [31:0]            jc_ff, jc_in;
   logic signed [31:0]            an_ff, an_in;

   // Shared multiplier
   logic signed [32:0]            mul_a_ff, mul_a_in;
   logic signed [32:0]            mul_b_ff, mul_b_in;
   logic signed [65:0]            prod_ff, prod_in;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]            rsp_vel_ff, rsp_vel_in;
   logic signed [31:0]            rsp_acc_ff, rsp_acc_in;
   logic signed [31:0]            rsp_jrk_ff, rsp_jrk_in;

   // Datapath signals
   logic                accept;
   logic                rsp_free;
   logic signed [31:0]  sm32;
   logic signed [31:0]  vg;
   logic                goal;
   logic [31:0]         vel_mag;
   logic [31:0]         vg_mag;
   logic                speed_up;
   logic signed [32:0]  err;
   logic [32:0]         err_mag;
   logic                err_small;
   logic [32:0]         kd_a;
   logic                acc_ok;
   logic                brake;
   logic signed [31:0]  jm32;
   logic signed [31:0]  jc;
   logic signed [31:0]  delta;
   logic signed [33:0]  acc_sum;
   logic signed [33:0]  am34;
   logic signed [31:0]  am32;
   logic signed [31:0]  acc_new;
   logic signed [32:0]  sum_acc;
   logic signed [31:0]  dv;
   logic signed [33:0]  vel_sum;
   logic signed [33:0]  vg34;
   logic signed [33:0]  sm34;
   logic signed [33:0]  vel_goal;
   logic signed [33:0]  vel_new;
   logic signed [1:0]   dir_cmd;
   logic signed [1:0]   dir_new;

   assign cw        = jlvp_pkg::ucode(upc_ff);
   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_velocity     = rsp_vel_ff;
   assign rsp_acceleration = rsp_acc_ff;
   assign rsp_jerk         = rsp_jrk_ff;

   // Goal, speed-up test and velocity error
   always_comb begin
      sm32 = $signed({1'b0, speed_max_ff});
      if (dir_ff == jlvp_pkg::DIR_FWD) begin
         vg = sm32;
      end else if (dir_ff == jlvp_pkg::DIR_REV) begin
         vg = -sm32;
      end else begin
         vg = '0;
      end
      goal    = (vel_ff == vg);
      vel_mag = jlvp_pkg::abs32(vel_ff);
      vg_mag  = jlvp_pkg::abs32(vg);
      if (acc_ff == '0) begin
         speed_up = ((vel_ff == '0) || (vg == '0) || (vel_ff[31] == vg[31]))
                    && (vel_mag < vg_mag);
      end else begin
         speed_up = (vel_ff == '0) || (vel_ff[31] == acc_ff[31]);
      end
      err = $signed({vg[31], vg}) - $signed({vel_ff[31], vel_ff});
   end

   // Braking test: |err| <= q + 7 with q = floor(a*a / 2j) <=> (|err|-7)*2j <= a*a
   always_comb begin
      err_mag   = err_ff[32] ? 33'(-err_ff) : 33'(err_ff);
      err_small = (err_mag <= jlvp_pkg::BRAKE_MARGIN);
      kd_a      = err_mag - jlvp_pkg::BRAKE_MARGIN;
      acc_ok    = (acc_ff == '0) || (acc_ff[31] == dr_neg_ff);
      brake     = acc_ok && (err_small || (prod_ff[63:0] <= sq_ff));
      jm32      = $signed({1'b0, jm_ff});
      jc        = (brake ^ dr_neg_ff) ? -jm32 : jm32;
   end

   // Acceleration update: a + floor(j*dt / 2^16), clamped to the active limit
   always_comb begin
      delta   = $signed(prod_ff[47:16]);
      acc_sum = $signed({{2{acc_ff[31]}}, acc_ff}) + $signed({{2{delta[31]}}, delta});
      am34    = $signed({3'b000, am_ff});
      am32    = $signed({1'b0, am_ff});
      if (acc_sum > am34) begin
         acc_new = am32;
      end else if (acc_sum < -am34) begin
         acc_new = -am32;
      end else begin
         acc_new = acc_sum[31:0];
      end
      sum_acc = $signed({acc_ff[31], acc_ff}) + $signed({an_ff[31], an_ff});
   end

   // Velocity update: v + floor((a_old + a_new)*dt / 2^17), clamped to goal and limit
   always_comb begin
      dv      = $signed(prod_ff[48:17]);
      vel_sum = $signed({{2{vel_ff[31]}}, vel_ff}) + $signed({{2{dv[31]}}, dv});
      vg34    = $signed({{2{vg_ff[31]}}, vg_ff});
      sm34    = $signed({3'b000, speed_max_ff});
      if (dr_neg_ff) begin
         vel_goal = (vel_sum < vg34) ? vg34 : vel_sum;
      end else begin
         vel_goal = (vel_sum > vg34) ? vg34 : vel_sum;
      end
      if (vel_goal > sm34) begin
         vel_new = sm34;
      end else if (vel_goal < -sm34) begin
         vel_new = -sm34;
      end else begin
         vel_new = vel_goal;
      end
   end

   // Direction command: clamp to -1..1, refuse a reversal while moving
   always_comb begin
      if (dir_req_ff == jlvp_pkg::DIR_FWD) begin
         dir_cmd = jlvp_pkg::DIR_FWD;
      end else if (dir_req_ff == jlvp_pkg::DIR_STOP) begin
         dir_cmd = jlvp_pkg::DIR_STOP;
      end else begin
         dir_cmd = jlvp_pkg::DIR_REV;
      end
      if ((!vel_ff[31] && (vel_ff != '0) && (dir_cmd == jlvp_pkg::DIR_REV))
          || (vel_ff[31] && (dir_cmd == jlvp_pkg::DIR_FWD))) begin
         dir_new = jlvp_pkg::DIR_STOP;
      end else begin
         dir_new = dir_cmd;
      end
   end

   // Next-state logic driven by the current control word
   always_comb begin
      tick_period_in = tick_period_ff;
      speed_max_in   = speed_max_ff;
      accel_limit_in = accel_limit_ff;
      accel_jerk_in  = accel_jerk_ff;
      decel_limit_in = decel_limit_ff;
      decel_jerk_in  = decel_jerk_ff;
      vel_in         = vel_ff;
      acc_in         = acc_ff;
      jrk_in         = jrk_ff;
      dir_in         = dir_ff;
      busy_in        = busy_ff;
      upc_in         = upc_ff;
      op_in          = op_ff;
      dir_req_in     = dir_req_ff;
      vg_in          = vg_ff;
      err_in         = err_ff;
      am_in          = am_ff;
      jm_in          = jm_ff;
      dr_neg_in      = dr_neg_ff;
      sq_in          = sq_ff;
      jc_in          = jc_ff;
      an_in          = an_ff;
      mul_a_in       = mul_a_ff;
      mul_b_in       = mul_b_ff;
      prod_in        = mul_a_ff * mul_b_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_vel_in     = rsp_vel_ff;
      rsp_acc_in     = rsp_acc_ff;
      rsp_jrk_in     = rsp_jrk_ff;

      // configuration writes
      if (csr_write_enable) begin
         case (csr_index)
            jlvp_pkg::CSR_TICK_PERIOD:
               tick_period_in = csr_write_data[jlvp_pkg::PERIOD_W-1:0];
            jlvp_pkg::CSR_SPEED_MAX:        speed_max_in   = csr_write_data;
            jlvp_pkg::CSR_ACCEL_LIMIT:      accel_limit_in = csr_write_data;
            jlvp_pkg::CSR_ACCEL_JERK_LIMIT: accel_jerk_in  = csr_write_data;
            jlvp_pkg::CSR_DECEL_LIMIT:      decel_limit_in = csr_write_data;
            jlvp_pkg::CSR_DECEL_JERK_LIMIT: decel_jerk_in  = csr_write_data;
            default: ;
         endcase
      end

      if (accept) begin
         // take the item and start the program
         busy_in    = 1'b1;
         upc_in     = jlvp_pkg::UPC_DISPATCH;
         op_in      = req_operation;
         dir_req_in = req_direction;
      end else if (busy_ff) begin
         // load multiplier operands
         case (cw.mul)
            jlvp_pkg::MUL_ACC_SQ: begin
               mul_a_in = $signed({acc_ff[31], acc_ff});
               mul_b_in = $signed({acc_ff[31], acc_ff});
            end
            jlvp_pkg::MUL_ERR_JERK: begin
               mul_a_in = $signed(kd_a);
               mul_b_in = $signed({1'b0, jm_ff, 1'b0});
            end
            jlvp_pkg::MUL_JERK_DT: begin
               mul_a_in = $signed({jc[31], jc});
               mul_b_in = $signed({17'd0, tick_period_ff});
            end
            jlvp_pkg::MUL_SUM_DT: begin
               mul_a_in = sum_acc;
               mul_b_in = $signed({17'd0, tick_period_ff});
            end
            default: ;
         endcase

         // datapath action
         case (cw.act)
            jlvp_pkg::ACT_SETUP: begin
               vg_in     = vg;
               err_in    = err;
               dr_neg_in = err[32];
               am_in     = speed_up ? accel_limit_ff : decel_limit_ff;
               jm_in     = speed_up ? accel_jerk_ff : decel_jerk_ff;
            end
            jlvp_pkg::ACT_SAVE_SQ: begin
               sq_in = prod_ff[63:0];
            end
            jlvp_pkg::ACT_BRAKE: begin
               jc_in = jc;
            end
            jlvp_pkg::ACT_ACCEL: begin
               an_in = acc_new;
            end
            jlvp_pkg::ACT_VEL: begin
               vel_in = vel_new[31:0];
               acc_in = an_ff;
               jrk_in = jc_ff;
            end
            jlvp_pkg::ACT_ZERO: begin
               acc_in = '0;
               jrk_in = '0;
            end
            jlvp_pkg::ACT_DIR: begin
               dir_in = dir_new;
            end
            jlvp_pkg::ACT_CLEAR: begin
               vel_in = '0;
               acc_in = '0;
               jrk_in = '0;
               dir_in = jlvp_pkg::DIR_STOP;
            end
            jlvp_pkg::ACT_RESULT: begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_vel_in   = vel_ff;
                  rsp_acc_in   = acc_ff;
                  rsp_jrk_in   = jrk_ff;
               end
            end
            default: ;
         endcase

         // advance the step counter
         case (cw.seq)
            jlvp_pkg::SEQ_NEXT:     upc_in = upc_ff + 1'b1;
            jlvp_pkg::SEQ_JUMP:     upc_in = cw.target;
            jlvp_pkg::SEQ_DISPATCH: upc_in = cw.target + {2'b00, op_ff};
            jlvp_pkg::SEQ_JUMP_GOAL: begin
               upc_in = goal ? cw.target : upc_ff + 1'b1;
            end
            jlvp_pkg::SEQ_FINISH: begin
               if (rsp_free) begin
                  busy_in = 1'b0;
               end
            end
            default: upc_in = jlvp_pkg::UPC_DONE;
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= jlvp_pkg::TICK_PERIOD_RST;
         speed_max_ff   <= jlvp_pkg::SPEED_MAX_RST;
         accel_limit_ff <= jlvp_pkg::ACCEL_LIMIT_RST;
         accel_jerk_ff  <= jlvp_pkg::ACCEL_JERK_LIMIT_RST;
         decel_limit_ff <= jlvp_pkg::DECEL_LIMIT_RST;
         decel_jerk_ff  <= jlvp_pkg::DECEL_JERK_LIMIT_RST;
         vel_ff         <= '0;
         acc_ff         <= '0;
         jrk_ff         <= '0;
         dir_ff         <= jlvp_pkg::DIR_STOP;
         busy_ff        <= 1'b0;
         upc_ff         <= jlvp_pkg::UPC_DISPATCH;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tick_period_ff <= tick_period_in;
         speed_max_ff   <= speed_max_in;
         accel_limit_ff <= accel_limit_in;
         accel_jerk_ff  <= accel_jerk_in;
         decel_limit_ff <= decel_limit_in;
         decel_jerk_ff  <= decel_jerk_in;
         vel_ff         <= vel_in;
         acc_ff         <= acc_in;
         jrk_ff         <= jrk_in;
         dir_ff         <= dir_in;
         busy_ff        <= busy_in;
         upc_ff         <= upc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload and scratch registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      dir_req_ff <= dir_req_in;
      vg_ff      <= vg_in;
      err_ff     <= err_in;
      am_ff      <= am_in;
      jm_ff      <= jm_in;
      dr_neg_ff  <= dr_neg_in;
      sq_ff      <= sq_in;
      jc_ff      <= jc_in;
      an_ff      <= an_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      prod_ff    <= prod_in;
      rsp_vel_ff <= rsp_vel_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_jrk_ff <= rsp_jrk_in;
   end

   // An accepted item starts at the dispatch step
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && (upc_ff == jlvp_pkg::UPC_DISPATCH)))
      else $error("accepted item did not start the program");

   // A result appears only out of the final step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff && (upc_ff == jlvp_pkg::UPC_DONE)))
      else $error("result raised outside the final step");

   // Integrated acceleration stays within the chosen limit
   a_accel_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !accept && (upc_ff == jlvp_pkg::UPC_ACCEL))
      |=> ((an_ff <= $signed({1'b0, am_ff})) && (an_ff >= -$signed({1'b0, am_ff}))))
      else $error("acceleration escaped its limit");

   // Committed velocity stays within the speed limit
   a_vel_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !accept && (upc_ff == jlvp_pkg::UPC_VEL))
      |=> ((vel_ff <= sm32) && (vel_ff >= -sm32)))
      else $error("velocity escaped the speed limit");

endmodule

### tb/sv/tb_jerk_limited_velocity_profiler_unit.sv
`timescale 1ns / 1ps

module tb_jerk_limited_velocity_profiler_unit;

   localparam int unsigned  DATA_W          = jlvp_pkg::DATA_W;
   localparam int unsigned  LIMIT_W         = jlvp_pkg::LIMIT_W;
   localparam int unsigned  PERIOD_W        = jlvp_pkg::PERIOD_W;
   localparam int unsigned  ITEMS_PER_PHASE = 94;
   localparam int unsigned  PHASE_COUNT     = 8;
   localparam int unsigned  IDLE_PERCENT    = 28;
   localparam int unsigned  HOLD_CYCLES     = 400;
   localparam int unsigned  SETTLE_CYCLES   = 16;
   localparam logic [30:0]  LIMIT_MAX       = 31'h7FFF_FFFF;
   localparam logic [2:0]   CSR_SPARE       = 3'd6;
   localparam logic [1:0]   DIR_CLAMPED     = 2'b10;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_DIRECTION = 2'd1,
      OP_CLEAR     = 2'd2,
      OP_SPARE     = 2'd3
   } op_code_type;

   typedef struct packed {
      logic [DATA_W-1:0] vel;
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] jerk;
   } motion_type;

   typedef struct packed {
      op_code_type op;
      logic [1:0]  dir;
      logic        typed;
      motion_type  result;
   } step_type;

   // Opening sequence under reset settings; zero results where they are obvious
   step_type directed_steps [0:24] = '{
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b1, '0},
      '{OP_SPARE,     jlvp_pkg::DIR_FWD,  1'b1, '0},
      '{OP_DIRECTION, jlvp_pkg::DIR_FWD,  1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_REV,  1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_FWD,  1'b0, '0},
      '{OP_TICK,      DIR_CLAMPED,        1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_DIRECTION, jlvp_pkg::DIR_REV,  1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_DIRECTION, jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_CLEAR,     jlvp_pkg::DIR_REV,  1'b1, '0},
      '{OP_DIRECTION, DIR_CLAMPED,        1'b1, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_DIRECTION, jlvp_pkg::DIR_FWD,  1'b0, '0},
      '{OP_TICK,      jlvp_pkg::DIR_STOP, 1'b0, '0},
      '{OP_CLEAR,     DIR_CLAMPED,        1'b1, '0},
      '{OP_TICK,      jlvp_pkg::DIR_FWD,  1'b1, '0}
   };

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_operation    = OP_TICK;
   logic signed [1:0]         req_direction    = jlvp_pkg::DIR_STOP;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic signed [DATA_W-1:0]  rsp_velocity;
   logic signed [DATA_W-1:0]  rsp_acceleration;
   logic signed [DATA_W-1:0]  rsp_jerk;
   logic                      csr_write_enable = 1'b0;
   logic [2:0]                csr_index        = jlvp_pkg::CSR_TICK_PERIOD;
   logic [LIMIT_W-1:0]        csr_write_data   = '0;

   // Profile state and register copies held by the predictor
   longint                    velocity_q;
   longint                    accel_q;
   longint                    jerk_q;
   longint                    heading_q;
   longint                    tick_period_q    = jlvp_pkg::TICK_PERIOD_RST;
   longint                    speed_max_q      = jlvp_pkg::SPEED_MAX_RST;
   longint                    accel_limit_q    = jlvp_pkg::ACCEL_LIMIT_RST;
   longint                    accel_jerk_q     = jlvp_pkg::ACCEL_JERK_LIMIT_RST;
   longint                    decel_limit_q    = jlvp_pkg::DECEL_LIMIT_RST;
   longint                    decel_jerk_q     = jlvp_pkg::DECEL_JERK_LIMIT_RST;

   motion_type                pending_motion[$];
   int unsigned               error_count      = 0;
   bit                        quiet            = 1'b0;
   bit                        hold_request     = 1'b0;

   jerk_limited_velocity_profiler_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_direction    (req_direction),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_velocity     (rsp_velocity),
      .rsp_acceleration (rsp_acceleration),
      .rsp_jerk         (rsp_jerk),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // Hard stop for a hung run
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic report(input string msg);
      $display("ERROR: %0s", msg);
      error_count++;
   endtask

   function automatic longint magnitude(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   // One control tick: pick limits, choose jerk, integrate and clamp
   function automatic void advance_profile();
      longint goal, speed, acc, amax, jmax, err, toward, jerk_cmd, prev;
      longint unsigned stop_dist;
      bit speed_up, brake;
      goal  = heading_q * speed_max_q;
      speed = velocity_q;
      acc   = accel_q;
      if (speed == goal) begin
         accel_q = 0;
         jerk_q  = 0;
         return;
      end
      if (acc == 0) begin
         speed_up = (speed * goal >= 0) && (magnitude(speed) < magnitude(goal));
      end else begin
         speed_up = (speed * acc >= 0);
      end
      amax   = speed_up ? accel_limit_q : decel_limit_q;
      jmax   = speed_up ? accel_jerk_q : decel_jerk_q;
      err    = goal - speed;
      toward = (err > 0) ? 1 : -1;

      // Brake once the remaining error fits the ramp-down distance
      brake = 1'b0;
      if (toward * acc >= 0) begin
         if (jmax == 0) begin
            brake = 1'b1;
         end else begin
            stop_dist = longint'(acc * acc);
            stop_dist = stop_dist / (2 * longint'(jmax));
            brake = (longint'(magnitude(err)) <= stop_dist + 7);
         end
      end
      jerk_cmd = brake ? -toward * jmax : toward * jmax;

      prev = acc;
      acc  = prev + ((jerk_cmd * tick_period_q) >>> 16);
      if (acc > amax) acc = amax;
      if (acc < -amax) acc = -amax;
      if (toward * acc >= 0 && toward * jerk_cmd <= 0) begin
         if (jerk_cmd < 0 && acc < 0) acc = 0;
         if (jerk_cmd > 0 && acc > 0) acc = 0;
      end

      // Trapezoid integration, then clamp to goal and speed limit
      speed += ((prev + acc) * tick_period_q) >>> 17;
      if (toward > 0) begin
         if (speed > goal) speed = goal;
      end else begin
         if (speed < goal) speed = goal;
      end
      if (speed > speed_max_q) speed = speed_max_q;
      if (speed < -speed_max_q) speed = -speed_max_q;

      velocity_q = speed;
      accel_q    = acc;
      jerk_q     = jerk_cmd;
   endfunction

   function automatic motion_type predict_motion(input op_code_type op,
                                                 input logic [1:0] dir);
      motion_type result;
      longint heading;
      case (op)
         OP_TICK: advance_profile();
         OP_DIRECTION: begin
            heading = longint'($signed(dir));
            if (heading < -1) heading = -1;
            // Refuse a command that would reverse a moving axis
            if ((velocity_q > 0 && heading < 0) || (velocity_q < 0 && heading > 0)) begin
               heading = 0;
            end
            heading_q = heading;
         end
         OP_CLEAR: begin
            velocity_q = 0;
            accel_q    = 0;
            jerk_q     = 0;
            heading_q  = 0;
         end
         default: ;
      endcase
      result.vel  = velocity_q[DATA_W-1:0];
      result.acc  = accel_q[DATA_W-1:0];
      result.jerk = jerk_q[DATA_W-1:0];
      return result;
   endfunction

   // Offer one item, hold it until taken, then queue its expected result
   task automatic send_item(input op_code_type op, input logic [1:0] dir,
                            input logic typed, input motion_type typed_result);
      motion_type want;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_direction <= dir;
      do @(posedge clock); while (!req_ready);
      want = predict_motion(op, dir);
      if (typed) want = typed_result;
      pending_motion.push_back(want);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_motion.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [LIMIT_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         jlvp_pkg::CSR_TICK_PERIOD:      tick_period_q = longint'(data[PERIOD_W-1:0]);
         jlvp_pkg::CSR_SPEED_MAX:        speed_max_q   = longint'(data);
         jlvp_pkg::CSR_ACCEL_LIMIT:      accel_limit_q = longint'(data);
         jlvp_pkg::CSR_ACCEL_JERK_LIMIT: accel_jerk_q  = longint'(data);
         jlvp_pkg::CSR_DECEL_LIMIT:      decel_limit_q = longint'(data);
         jlvp_pkg::CSR_DECEL_JERK_LIMIT: decel_jerk_q  = longint'(data);
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [LIMIT_W-1:0] random_limit(input logic [LIMIT_W-1:0] floor_val);
      logic [LIMIT_W-1:0] value;
      value = LIMIT_W'($urandom_range(32'(LIMIT_MAX >> $urandom_range(24, 0))));
      if (value < floor_val) value = floor_val;
      return value;
   endfunction

   task automatic configure_phase(input int unsigned phase);
      case (phase)
         0: begin
            // Largest settings everywhere; extra bits above the period are dropped
            write_register(jlvp_pkg::CSR_TICK_PERIOD, LIMIT_MAX);
            write_register(jlvp_pkg::CSR_SPEED_MAX, LIMIT_MAX);
            write_register(jlvp_pkg::CSR_ACCEL_LIMIT, LIMIT_MAX);
            write_register(jlvp_pkg::CSR_ACCEL_JERK_LIMIT, LIMIT_MAX);
            write_register(jlvp_pkg::CSR_DECEL_LIMIT, LIMIT_MAX);
            write_register(jlvp_pkg::CSR_DECEL_JERK_LIMIT, LIMIT_MAX);
         end
         1: begin
            write_register(jlvp_pkg::CSR_TICK_PERIOD, 31'd1);
            write_register(jlvp_pkg::CSR_SPEED_MAX, 31'd0);
            write_register(jlvp_pkg::CSR_ACCEL_LIMIT, 31'd1);
            write_register(jlvp_pkg::CSR_ACCEL_JERK_LIMIT, 31'd1);
            write_register(jlvp_pkg::CSR_DECEL_LIMIT, 31'd1);
            write_register(jlvp_pkg::CSR_DECEL_JERK_LIMIT, 31'd1);
         end
         default: begin
            write_register(jlvp_pkg::CSR_TICK_PERIOD,
                           {15'($urandom), 16'($urandom_range(65535, 1))});
            write_register(jlvp_pkg::CSR_SPEED_MAX, random_limit(31'd0));
            write_register(jlvp_pkg::CSR_ACCEL_LIMIT, random_limit(31'd1));
            write_register(jlvp_pkg::CSR_ACCEL_JERK_LIMIT, random_limit(31'd1));
            write_register(jlvp_pkg::CSR_DECEL_LIMIT, random_limit(31'd1));
            write_register(jlvp_pkg::CSR_DECEL_JERK_LIMIT, random_limit(31'd1));
            if (phase == 2) write_register(CSR_SPARE, LIMIT_W'($urandom));
         end
      endcase
   endtask

   // Receiver: random stalls, one long hold-off on request
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      motion_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_motion.size() == 0) begin
            report($sformatf("result with nothing expected: v %h a %h j %h",
                             rsp_velocity, rsp_acceleration, rsp_jerk));
         end else begin
            want = pending_motion.pop_front();
            if (rsp_velocity !== want.vel)
               report($sformatf("velocity got %h want %h", rsp_velocity, want.vel));
            if (rsp_acceleration !== want.acc)
               report($sformatf("acceleration got %h want %h", rsp_acceleration, want.acc));
            if (rsp_jerk !== want.jerk)
               report($sformatf("jerk got %h want %h", rsp_jerk, want.jerk));
         end
      end
   end

   // Main sequence: reset, directed table, then randomized phases
   initial begin
      int unsigned phase, sent, pick, run, k;
      logic [1:0]  heading;
      velocity_q = 0;
      accel_q    = 0;
      jerk_q     = 0;
      heading_q  = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < $size(directed_steps); k++) begin
         send_item(directed_steps[k].op, directed_steps[k].dir,
                   directed_steps[k].typed, directed_steps[k].result);
      end
      wait_drained();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         configure_phase(phase);
         quiet = (phase == 2);
         if (phase == 3) hold_request = 1'b1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
               // Direction command followed by a run of ticks, or a bare run
               if (pick < 60) begin
                  case ($urandom_range(2))
                     0: heading = jlvp_pkg::DIR_FWD;
                     1: heading = jlvp_pkg::DIR_REV;
                     default: heading = jlvp_pkg::DIR_STOP;
                  endcase
                  send_item(OP_DIRECTION, heading, 1'b0, '0);
                  sent++;
               end
               run = $urandom_range(30, 4);
               repeat (run) send_item(OP_TICK, 2'($urandom), 1'b0, '0);
               sent += run;
            end else if (pick < 88) begin
               send_item(OP_CLEAR, 2'($urandom), 1'b0, '0);
               sent++;
            end else if (pick < 94) begin
               send_item(OP_SPARE, 2'($urandom), 1'b0, '0);
            end else begin
               send_item(OP_DIRECTION, DIR_CLAMPED, 1'b0, '0);
               sent++;
            end
         end
         wait_drained();
         quiet = 1'b0;
      end

      if (error_count == 0 && pending_motion.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### jerk_limited_velocity_profiler_unit.f
design/jlvp_pkg.sv
design/jerk_limited_velocity_profiler_unit.sv
tb/sv/tb_jerk_limited_velocity_profiler_unit.sv
